>>> sv/hrv_pkg.sv
// Shared widths, reset values, register indexes and operation codes for the
// heart-rate-variability statistics block. No dependencies.
`default_nettype none

package hrv_pkg;

    localparam int RATE_W    = 8;
    localparam int THR_W     = 8;
    localparam int NUM_W     = 16;
    localparam int RR_W      = 16;
    localparam int SUM_W     = 24;
    localparam int SQ_W      = 40;
    localparam int OUT_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;

    localparam int MAX_INTERVALS_DEF = 255;

    localparam logic [THR_W-1:0] START_THR_RST  = 8'd40;
    localparam logic [THR_W-1:0] ACCEPT_THR_RST = 8'd60;
    localparam logic [NUM_W-1:0] NUMER_RST      = 16'd60000;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_END    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_THR  = 2'd0,
        CFG_ACCEPT_THR = 2'd1,
        CFG_NUMER      = 2'd2
    } cfg_idx_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

>>> sv/hrv_rr_statistics_top.sv
// Heart-rate-variability statistics: RR interval accumulation and SDNN per period.
// A heart-rate beat (tuser 0) that yields no RR interval is finished in the idle
// state. One that yields an interval runs the bit-serial divider (numerator by
// rate) and then the bit-serial multiplier to square it. A period-end beat
// (tuser 1) with collected intervals runs two serial multiplies, then the square
// root in parallel with the mean division, then the SDNN division; it then waits
// only if the previous result beat is still on the output register. A new input
// beat is taken only once the current one is finished, while an earlier result
// may still sit on the output. Configuration writes take effect at once.
// Depends on hrv_pkg, hrv_div, hrv_mul and hrv_isqrt.
`default_nettype none

module hrv_rr_statistics_top #(
    parameter int MAX_INTERVALS = hrv_pkg::MAX_INTERVALS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [hrv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hrv_pkg::CFG_W-1:0]     cfg_data,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hrv_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] heart_rate
    input  logic [hrv_pkg::S_TUSER_W-1:0] s_tuser,   // [0] operation
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hrv_pkg::M_TDATA_W-1:0] m_tdata    // [7:0] last_rate, [23:8] mean_rr,
                                                     // [39:24] sdnn
);

    localparam int RATE_W = hrv_pkg::RATE_W;
    localparam int SUM_W  = hrv_pkg::SUM_W;
    localparam int SQ_W   = hrv_pkg::SQ_W;
    localparam int RR_W   = hrv_pkg::RR_W;
    localparam int OUT_W  = hrv_pkg::OUT_W;
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int MB_W   = hrv_pkg::max_int(SUM_W, CNT_W);
    localparam int PROD_W = SQ_W + MB_W;
    localparam int DIFF_W = hrv_pkg::max_int(CNT_W + SQ_W, 2 * SUM_W);
    localparam int ROOT_W = (DIFF_W + 1) / 2;
    localparam int DVD_W  = ROOT_W;
    localparam int DVS_W  = hrv_pkg::max_int(RATE_W, CNT_W);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RR_DIV,
        ST_RR_SQ,
        ST_NQ,
        ST_SS,
        ST_ROOT,
        ST_SD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [hrv_pkg::THR_W-1:0] start_thr_reg, start_thr_next;
    logic [hrv_pkg::THR_W-1:0] accept_thr_reg, accept_thr_next;
    logic [hrv_pkg::NUM_W-1:0] numer_reg, numer_next;

    logic                      started_reg, started_next;
    logic [RATE_W-1:0]         rate_hold_reg, rate_hold_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [SQ_W-1:0]           sq_sum_reg, sq_sum_next;

    logic [RR_W-1:0]           rr_reg, rr_next;
    logic [DIFF_W-1:0]         nq_reg, nq_next;
    logic [OUT_W-1:0]          mean_reg, mean_next;
    logic [OUT_W-1:0]          sd_reg, sd_next;
    logic                      mean_ok_reg, mean_ok_next;
    logic                      root_ok_reg, root_ok_next;

    logic                      div_start_reg, div_start_next;
    logic [DVD_W-1:0]          div_dvd_reg, div_dvd_next;
    logic [DVS_W-1:0]          div_dvs_reg, div_dvs_next;
    logic                      mul_start_reg, mul_start_next;
    logic [SQ_W-1:0]           mul_a_reg, mul_a_next;
    logic [MB_W-1:0]           mul_b_reg, mul_b_next;
    logic                      sqrt_start_reg, sqrt_start_next;
    logic [2*ROOT_W-1:0]       sqrt_in_reg, sqrt_in_next;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic [hrv_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                      div_done;
    logic [DVD_W-1:0]          div_quot;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_prod;
    logic                      sqrt_done;
    logic [ROOT_W-1:0]         sqrt_root;

    logic [RATE_W-1:0]         rate_in;
    logic                      op_in;
    logic                      started_now;
    logic [DIFF_W-1:0]         ss_val;
    logic [DIFF_W:0]           diff_wide;

    hrv_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dvs_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    hrv_mul #(
        .A_W (SQ_W),
        .B_W (MB_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    hrv_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_in_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        rate_in     = s_tdata[RATE_W-1:0];
        op_in       = s_tuser[0];
        started_now = started_reg | (rate_in > start_thr_reg);
        ss_val      = DIFF_W'(mul_prod);
        diff_wide   = {1'b0, nq_reg} - {1'b0, ss_val};

        state_next      = state_reg;
        start_thr_next  = start_thr_reg;
        accept_thr_next = accept_thr_reg;
        numer_next      = numer_reg;
        started_next    = started_reg;
        rate_hold_next  = rate_hold_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        sq_sum_next     = sq_sum_reg;
        rr_next         = rr_reg;
        nq_next         = nq_reg;
        mean_next       = mean_reg;
        sd_next         = sd_reg;
        mean_ok_next    = mean_ok_reg;
        root_ok_next    = root_ok_reg;
        div_start_next  = 1'b0;
        div_dvd_next    = div_dvd_reg;
        div_dvs_next    = div_dvs_reg;
        mul_start_next  = 1'b0;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        sqrt_start_next = 1'b0;
        sqrt_in_next    = sqrt_in_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (cfg_wr_en)
        begin
            case (hrv_pkg::cfg_idx_t'(cfg_index))
                hrv_pkg::CFG_START_THR:  start_thr_next  = cfg_data[hrv_pkg::THR_W-1:0];
                hrv_pkg::CFG_ACCEPT_THR: accept_thr_next = cfg_data[hrv_pkg::THR_W-1:0];
                hrv_pkg::CFG_NUMER:      numer_next      = cfg_data[hrv_pkg::NUM_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (op_in == hrv_pkg::OP_REPORT)
                    begin
                        rate_hold_next = rate_in;
                        started_next   = started_now;
                        // A full count drops the interval, so the divide is skipped.
                        if (started_now && (rate_in > accept_thr_reg) && (count_reg < CNT_MAX))
                        begin
                            div_start_next = 1'b1;
                            div_dvd_next   = DVD_W'(numer_reg);
                            div_dvs_next   = DVS_W'(rate_in);
                            state_next     = ST_RR_DIV;
                        end
                    end
                    else if (started_reg && (count_reg != '0))
                    begin
                        mul_start_next = 1'b1;
                        mul_a_next     = sq_sum_reg;
                        mul_b_next     = MB_W'(count_reg);
                        state_next     = ST_NQ;
                    end
                end
            end
            ST_RR_DIV:
            begin
                if (div_done)
                begin
                    rr_next        = div_quot[RR_W-1:0];
                    mul_start_next = 1'b1;
                    mul_a_next     = SQ_W'(div_quot[RR_W-1:0]);
                    mul_b_next     = MB_W'(div_quot[RR_W-1:0]);
                    state_next     = ST_RR_SQ;
                end
            end
            ST_RR_SQ:
            begin
                if (mul_done)
                begin
                    count_next  = count_reg + CNT_W'(1);
                    sum_next    = sum_reg + SUM_W'(rr_reg);
                    sq_sum_next = sq_sum_reg + mul_prod[SQ_W-1:0];
                    state_next  = ST_IDLE;
                end
            end
            ST_NQ:
            begin
                if (mul_done)
                begin
                    nq_next        = mul_prod[DIFF_W-1:0];
                    mul_start_next = 1'b1;
                    mul_a_next     = SQ_W'(sum_reg);
                    mul_b_next     = MB_W'(sum_reg);
                    state_next     = ST_SS;
                end
            end
            ST_SS:
            begin
                if (mul_done)
                begin
                    // A wrapped square sum can make the variance term negative; it
                    // is clamped to zero.
                    sqrt_in_next    = diff_wide[DIFF_W] ? '0
                                                        : (2*ROOT_W)'(diff_wide[DIFF_W-1:0]);
                    sqrt_start_next = 1'b1;
                    div_start_next  = 1'b1;
                    div_dvd_next    = DVD_W'(sum_reg);
                    div_dvs_next    = DVS_W'(count_reg);
                    mean_ok_next    = 1'b0;
                    root_ok_next    = 1'b0;
                    state_next      = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (div_done)
                begin
                    mean_ok_next = 1'b1;
                    mean_next    = div_quot[OUT_W-1:0];
                end
                if (sqrt_done)
                begin
                    root_ok_next = 1'b1;
                end
                if ((mean_ok_reg || div_done) && (root_ok_reg || sqrt_done))
                begin
                    div_start_next = 1'b1;
                    div_dvd_next   = DVD_W'(sqrt_root);
                    div_dvs_next   = DVS_W'(count_reg);
                    state_next     = ST_SD;
                end
            end
            ST_SD:
            begin
                if (div_done)
                begin
                    sd_next    = div_quot[OUT_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {sd_reg, mean_reg, rate_hold_reg};
                    count_next    = '0;
                    sum_next      = '0;
                    sq_sum_next   = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_thr_reg  <= hrv_pkg::START_THR_RST;
            accept_thr_reg <= hrv_pkg::ACCEPT_THR_RST;
            numer_reg      <= hrv_pkg::NUMER_RST;
            started_reg    <= 1'b0;
            rate_hold_reg  <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            sq_sum_reg     <= '0;
            rr_reg         <= '0;
            nq_reg         <= '0;
            mean_reg       <= '0;
            sd_reg         <= '0;
            mean_ok_reg    <= 1'b0;
            root_ok_reg    <= 1'b0;
            div_start_reg  <= 1'b0;
            div_dvd_reg    <= '0;
            div_dvs_reg    <= '0;
            mul_start_reg  <= 1'b0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            sqrt_start_reg <= 1'b0;
            sqrt_in_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            start_thr_reg  <= start_thr_next;
            accept_thr_reg <= accept_thr_next;
            numer_reg      <= numer_next;
            started_reg    <= started_next;
            rate_hold_reg  <= rate_hold_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            sq_sum_reg     <= sq_sum_next;
            rr_reg         <= rr_next;
            nq_reg         <= nq_next;
            mean_reg       <= mean_next;
            sd_reg         <= sd_next;
            mean_ok_reg    <= mean_ok_next;
            root_ok_reg    <= root_ok_next;
            div_start_reg  <= div_start_next;
            div_dvd_reg    <= div_dvd_next;
            div_dvs_reg    <= div_dvs_next;
            mul_start_reg  <= mul_start_next;
            mul_a_reg      <= mul_a_next;
            mul_b_reg      <= mul_b_next;
            sqrt_start_reg <= sqrt_start_next;
            sqrt_in_reg    <= sqrt_in_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The interval count never passes its ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("interval count above its maximum");

    // The multiplier only reports completion in a state that waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_RR_SQ || state_reg == ST_NQ || state_reg == ST_SS))
        else $error("multiplier finished outside a multiply state");

    // The divider only reports completion in a state that waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_RR_DIV || state_reg == ST_ROOT || state_reg == ST_SD))
        else $error("divider finished outside a divide state");

    // A result is only formed for a started period with collected intervals.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (started_reg && count_reg != '0))
        else $error("result formed without collected intervals");

    // A period end with collected intervals starts the statistics sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] == hrv_pkg::OP_END && started_reg
         && count_reg != '0) |=> (state_reg == ST_NQ && mul_start_reg))
        else $error("period end did not start the statistics sequence");

endmodule

`default_nettype wire

>>> sv/hrv_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Stand-alone; used by hrv_rr_statistics_top.
`default_nettype none

module hrv_div #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   left;
    logic             fits;

    always_comb
    begin
        // The dividend shifts out at the top while quotient bits shift in at the bottom.
        trial     = {rem_reg, quot_reg[DVD_W-1]};
        left      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DVD_W-2:0], fits};
            rem_next  = fits ? left[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

>>> sv/hrv_mul.sv
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
// Stand-alone; used by hrv_rr_statistics_top.
`default_nettype none

module hrv_mul #(
    parameter int A_W = 40,
    parameter int B_W = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg, acc_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [A_W:0]     part;

    always_comb
    begin
        // The multiplier sits in the low half and is shifted out as the product grows in.
        part      = {1'b0, acc_reg[P_W-1:B_W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = {{A_W{1'b0}}, b};
            a_next    = a;
            cnt_next  = CNT_W'(B_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {part, acc_reg[B_W-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            a_reg    <= a_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

>>> sv/hrv_isqrt.sv
// Digit-by-digit floor square root, one root bit (two radicand bits) per cycle.
// Stand-alone; used by hrv_rr_statistics_top.
`default_nettype none

module hrv_isqrt #(
    parameter int ROOT_W = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2*ROOT_W-1:0] radicand,
    output logic                done,
    output logic [ROOT_W-1:0]   root
);

    localparam int IN_W  = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [IN_W-1:0]   val_reg, val_next;
    logic [ROOT_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ROOT_W+1:0] pair;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] left;
    logic              fits;

    always_comb
    begin
        // Before the final step the remainder is at most twice the partial root,
        // so it fits in ROOT_W bits.
        pair      = {rem_reg, val_reg[IN_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        left      = pair - trial;
        fits      = (pair >= trial);
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next  = {val_reg[IN_W-3:0], 2'b00};
            rem_next  = fits ? left[ROOT_W-1:0] : pair[ROOT_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            val_reg  <= val_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire
